[hdl/kfq_pkg.sv]
// Package: sizes, codes, control word layout and microcode ROM for the keyed queue.
`timescale 1ns / 1ps

package kfq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int UPC_W = 5;

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_POP    = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_PEEK   = 3'd3;
  localparam logic [2:0] MODE_GET    = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Microcode addresses
  localparam logic [UPC_W-1:0] U_FETCH  = 5'd0;
  localparam logic [UPC_W-1:0] U_DISP   = 5'd1;
  localparam logic [UPC_W-1:0] U_A0     = 5'd2;
  localparam logic [UPC_W-1:0] U_A1     = 5'd3;
  localparam logic [UPC_W-1:0] U_AFULL  = 5'd4;
  localparam logic [UPC_W-1:0] U_S0     = 5'd5;
  localparam logic [UPC_W-1:0] U_S1     = 5'd6;
  localparam logic [UPC_W-1:0] U_S2     = 5'd7;
  localparam logic [UPC_W-1:0] U_S3     = 5'd8;
  localparam logic [UPC_W-1:0] U_MISS   = 5'd9;
  localparam logic [UPC_W-1:0] U_H0     = 5'd10;
  localparam logic [UPC_W-1:0] U_H1     = 5'd11;
  localparam logic [UPC_W-1:0] U_HIT    = 5'd12;
  localparam logic [UPC_W-1:0] U_CU0    = 5'd13;
  localparam logic [UPC_W-1:0] U_CU1    = 5'd14;
  localparam logic [UPC_W-1:0] U_CU2    = 5'd15;
  localparam logic [UPC_W-1:0] U_CUEND  = 5'd16;
  localparam logic [UPC_W-1:0] U_END    = 5'd17;

  typedef enum logic [1:0] {
    OP_WAIT,      // hold until a word arrives, capture it
    OP_SEQ,       // jump to target if condition, else next step
    OP_DISPATCH,  // jump by operation code
    OP_DONE       // hand the result to the output register, back to fetch
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_FULL,
    C_EMPTY,
    C_MATCH,
    C_LAST,
    C_NOT_LAST,
    C_KEEP
  } ucond_t;

  typedef enum logic [1:0] {I_HOLD, I_CLEAR, I_INC} idx_act_t;
  typedef enum logic [2:0] {M_NONE, M_RD_IDX, M_RD_NEXT, M_WR_TAIL, M_WR_IDX} mem_act_t;
  typedef enum logic [1:0] {N_HOLD, N_INC, N_DEC} cnt_act_t;
  typedef enum logic [2:0] {R_NONE, R_OKZ, R_FULL, R_MISS, R_HIT} res_act_t;

  typedef struct packed {
    uop_t             op;
    ucond_t           cond;
    logic [UPC_W-1:0] target;
    idx_act_t         idx_act;
    mem_act_t         mem_act;
    cnt_act_t         cnt_act;
    res_act_t         res_act;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic   go;
    uword_t w;
  } cmd_t;

  // Datapath to sequencer
  typedef struct packed {
    logic       full;
    logic       empty;
    logic       match;
    logic       last;
    logic       keep;
    logic       in_avail;
    logic       out_free;
    logic [2:0] mode;
  } flags_t;

  function automatic uword_t uw(uop_t op, ucond_t cond, logic [UPC_W-1:0] target,
                                idx_act_t ia, mem_act_t ma, cnt_act_t na, res_act_t ra);
    uword_t w;
    w.op      = op;
    w.cond    = cond;
    w.target  = target;
    w.idx_act = ia;
    w.mem_act = ma;
    w.cnt_act = na;
    w.res_act = ra;
    return w;
  endfunction

  // Microprogram
  function automatic uword_t urom(logic [UPC_W-1:0] a);
    uword_t w;
    unique case (a)
      U_FETCH: w = uw(OP_WAIT,     C_NEVER,    U_FETCH, I_HOLD,  M_NONE,    N_HOLD, R_NONE);
      U_DISP:  w = uw(OP_DISPATCH, C_NEVER,    U_FETCH, I_HOLD,  M_NONE,    N_HOLD, R_NONE);
      U_A0:    w = uw(OP_SEQ,      C_FULL,     U_AFULL, I_HOLD,  M_NONE,    N_HOLD, R_NONE);
      U_A1:    w = uw(OP_DONE,     C_NEVER,    U_FETCH, I_HOLD,  M_WR_TAIL, N_INC,  R_OKZ);
      U_AFULL: w = uw(OP_DONE,     C_NEVER,    U_FETCH, I_HOLD,  M_NONE,    N_HOLD, R_FULL);
      U_S0:    w = uw(OP_SEQ,      C_EMPTY,    U_MISS,  I_CLEAR, M_NONE,    N_HOLD, R_NONE);
      U_S1:    w = uw(OP_SEQ,      C_NEVER,    U_FETCH, I_HOLD,  M_RD_IDX,  N_HOLD, R_NONE);
      U_S2:    w = uw(OP_SEQ,      C_MATCH,    U_HIT,   I_HOLD,  M_NONE,    N_HOLD, R_NONE);
      U_S3:    w = uw(OP_SEQ,      C_NOT_LAST, U_S1,    I_INC,   M_NONE,    N_HOLD, R_NONE);
      U_MISS:  w = uw(OP_DONE,     C_NEVER,    U_FETCH, I_HOLD,  M_NONE,    N_HOLD, R_MISS);
      U_H0:    w = uw(OP_SEQ,      C_EMPTY,    U_MISS,  I_CLEAR, M_NONE,    N_HOLD, R_NONE);
      U_H1:    w = uw(OP_SEQ,      C_NEVER,    U_FETCH, I_HOLD,  M_RD_IDX,  N_HOLD, R_NONE);
      U_HIT:   w = uw(OP_SEQ,      C_KEEP,     U_END,   I_HOLD,  M_NONE,    N_HOLD, R_HIT);
      U_CU0:   w = uw(OP_SEQ,      C_LAST,     U_CUEND, I_HOLD,  M_NONE,    N_HOLD, R_NONE);
      U_CU1:   w = uw(OP_SEQ,      C_NEVER,    U_FETCH, I_HOLD,  M_RD_NEXT, N_HOLD, R_NONE);
      U_CU2:   w = uw(OP_SEQ,      C_ALWAYS,   U_CU0,   I_INC,   M_WR_IDX,  N_HOLD, R_NONE);
      U_CUEND: w = uw(OP_DONE,     C_NEVER,    U_FETCH, I_HOLD,  M_NONE,    N_DEC,  R_NONE);
      U_END:   w = uw(OP_DONE,     C_NEVER,    U_FETCH, I_HOLD,  M_NONE,    N_HOLD, R_NONE);
      default: w = uw(OP_SEQ,      C_ALWAYS,   U_FETCH, I_HOLD,  M_NONE,    N_HOLD, R_NONE);
    endcase
    return w;
  endfunction

  // Entry point of each operation
  function automatic logic [UPC_W-1:0] dispatch(logic [2:0] mode);
    logic [UPC_W-1:0] a;
    unique case (mode)
      MODE_APPEND:         a = U_A0;
      MODE_POP, MODE_PEEK: a = U_H0;
      MODE_REMOVE,
      MODE_GET:            a = U_S0;
      default:             a = U_MISS;
    endcase
    return a;
  endfunction

endpackage

[hdl/kfq_if.sv]
// Channel interfaces: operation words in, result words out.
`timescale 1ns / 1ps

interface kfq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] key_letter;
  logic [7:0] entry_value;

  modport source (output valid, mode, key_letter, entry_value, input ready);
  modport sink   (input valid, mode, key_letter, entry_value, output ready);
endinterface

interface kfq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_letter;
  logic [7:0] out_value;
  logic [4:0] entry_count;

  modport source (output valid, status, out_letter, out_value, entry_count, input ready);
  modport sink   (input valid, status, out_letter, out_value, entry_count, output ready);
endinterface

[hdl/kfq_useq.sv]
// Microcode sequencer: step counter, control ROM, condition select and jumps.
`timescale 1ns / 1ps

module kfq_useq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kfq_pkg::flags_t      flags,
  output kfq_pkg::cmd_t        cmd
);

  logic [kfq_pkg::UPC_W-1:0] upc_r;
  logic [kfq_pkg::UPC_W-1:0] upc_nxt;
  kfq_pkg::uword_t           w;
  logic                      cond_true;
  logic                      go;

  assign w = kfq_pkg::urom(upc_r);

  always_comb begin
    unique case (w.cond)
      kfq_pkg::C_NEVER:    cond_true = 1'b0;
      kfq_pkg::C_ALWAYS:   cond_true = 1'b1;
      kfq_pkg::C_FULL:     cond_true = flags.full;
      kfq_pkg::C_EMPTY:    cond_true = flags.empty;
      kfq_pkg::C_MATCH:    cond_true = flags.match;
      kfq_pkg::C_LAST:     cond_true = flags.last;
      kfq_pkg::C_NOT_LAST: cond_true = !flags.last;
      kfq_pkg::C_KEEP:     cond_true = flags.keep;
      default:             cond_true = 1'b0;
    endcase
  end

  // Stall on an empty input or a still-occupied output register
  always_comb begin
    go = 1'b1;
    if (w.op == kfq_pkg::OP_WAIT && !flags.in_avail) go = 1'b0;
    if (w.op == kfq_pkg::OP_DONE && !flags.out_free) go = 1'b0;
  end

  always_comb begin
    upc_nxt = upc_r;
    if (go) begin
      unique case (w.op)
        kfq_pkg::OP_WAIT:     upc_nxt = kfq_pkg::U_DISP;
        kfq_pkg::OP_SEQ:      upc_nxt = cond_true ? w.target : upc_r + 5'd1;
        kfq_pkg::OP_DISPATCH: upc_nxt = kfq_pkg::dispatch(flags.mode);
        kfq_pkg::OP_DONE:     upc_nxt = kfq_pkg::U_FETCH;
        default:              upc_nxt = kfq_pkg::U_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= kfq_pkg::U_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign cmd.go = go;
  assign cmd.w  = w;

endmodule

[hdl/kfq_dp.sv]
// Datapath: entry memory, index and count registers, result and output registers.
`timescale 1ns / 1ps

module kfq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  kfq_pkg::cmd_t     cmd,
  output kfq_pkg::flags_t   flags,
  kfq_in_if.sink            in_ch,
  kfq_out_if.source         out_ch
);

  logic [7:0] let_mem [kfq_pkg::DEPTH];
  logic [7:0] val_mem [kfq_pkg::DEPTH];

  logic [2:0]                mode_r;
  logic [7:0]                key_r;
  logic [7:0]                val_r;
  logic [kfq_pkg::IDX_W-1:0] idx_r;
  logic [kfq_pkg::CNT_W-1:0] cnt_r;
  logic [kfq_pkg::CNT_W-1:0] cnt_nxt;
  logic [7:0]                rd_let_r;
  logic [7:0]                rd_val_r;
  logic [1:0]                res_st_r;
  logic [7:0]                res_let_r;
  logic [7:0]                res_val_r;
  logic [1:0]                res_st_nxt;
  logic [7:0]                res_let_nxt;
  logic [7:0]                res_val_nxt;
  logic                      out_valid_r;
  logic [1:0]                out_st_r;
  logic [7:0]                out_let_r;
  logic [7:0]                out_val_r;
  logic [4:0]                out_cnt_r;
  logic [kfq_pkg::IDX_W-1:0] rd_addr;
  logic [kfq_pkg::IDX_W-1:0] wr_addr;
  logic                      accept;
  logic                      done;

  assign in_ch.ready = (cmd.w.op == kfq_pkg::OP_WAIT);
  assign accept      = in_ch.valid && in_ch.ready;
  assign done        = cmd.go && (cmd.w.op == kfq_pkg::OP_DONE);

  assign flags.full     = (cnt_r == kfq_pkg::CNT_W'(kfq_pkg::DEPTH));
  assign flags.empty    = (cnt_r == '0);
  assign flags.match    = (rd_let_r == key_r);
  assign flags.last     = (kfq_pkg::CNT_W'(idx_r) + kfq_pkg::CNT_W'(1) == cnt_r);
  assign flags.keep     = (mode_r == kfq_pkg::MODE_PEEK) || (mode_r == kfq_pkg::MODE_GET);
  assign flags.in_avail = in_ch.valid;
  assign flags.out_free = !out_valid_r || out_ch.ready;
  assign flags.mode     = mode_r;

  assign rd_addr = (cmd.w.mem_act == kfq_pkg::M_RD_NEXT) ? idx_r + kfq_pkg::IDX_W'(1) : idx_r;
  assign wr_addr = (cmd.w.mem_act == kfq_pkg::M_WR_TAIL) ? kfq_pkg::IDX_W'(cnt_r) : idx_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_ch.mode;
      key_r  <= in_ch.key_letter;
      val_r  <= in_ch.entry_value;
    end
  end

  // Entry memory: one access per cycle, either a write or a registered read, on unstalled steps only
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      if (cmd.w.mem_act == kfq_pkg::M_WR_TAIL) begin
        let_mem[wr_addr] <= key_r;
        val_mem[wr_addr] <= val_r;
      end else if (cmd.w.mem_act == kfq_pkg::M_WR_IDX) begin
        let_mem[wr_addr] <= rd_let_r;
        val_mem[wr_addr] <= rd_val_r;
      end
      if (cmd.w.mem_act == kfq_pkg::M_RD_IDX || cmd.w.mem_act == kfq_pkg::M_RD_NEXT) begin
        rd_let_r <= let_mem[rd_addr];
        rd_val_r <= val_mem[rd_addr];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.go) begin
      unique case (cmd.w.cnt_act)
        kfq_pkg::N_INC: cnt_nxt = cnt_r + kfq_pkg::CNT_W'(1);
        kfq_pkg::N_DEC: cnt_nxt = cnt_r - kfq_pkg::CNT_W'(1);
        default:        cnt_nxt = cnt_r;
      endcase
    end
  end

  always_comb begin
    res_st_nxt  = res_st_r;
    res_let_nxt = res_let_r;
    res_val_nxt = res_val_r;
    if (cmd.go) begin
      unique case (cmd.w.res_act)
        kfq_pkg::R_OKZ: begin
          res_st_nxt  = kfq_pkg::ST_OK;
          res_let_nxt = 8'd0;
          res_val_nxt = 8'd0;
        end
        kfq_pkg::R_FULL: begin
          res_st_nxt  = kfq_pkg::ST_FULL;
          res_let_nxt = 8'd0;
          res_val_nxt = 8'd0;
        end
        kfq_pkg::R_MISS: begin
          res_st_nxt  = kfq_pkg::ST_MISS;
          res_let_nxt = 8'd0;
          res_val_nxt = 8'd0;
        end
        kfq_pkg::R_HIT: begin
          res_st_nxt  = kfq_pkg::ST_OK;
          res_let_nxt = rd_let_r;
          res_val_nxt = rd_val_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    res_st_r  <= res_st_nxt;
    res_let_r <= res_let_nxt;
    res_val_r <= res_val_nxt;
    if (done) begin
      out_st_r  <= res_st_nxt;
      out_let_r <= res_let_nxt;
      out_val_r <= res_val_nxt;
      out_cnt_r <= 5'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.go) begin
        unique case (cmd.w.idx_act)
          kfq_pkg::I_CLEAR: idx_r <= '0;
          kfq_pkg::I_INC:   idx_r <= idx_r + kfq_pkg::IDX_W'(1);
          default:          idx_r <= idx_r;
        endcase
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.out_letter  = out_let_r;
  assign out_ch.out_value   = out_val_r;
  assign out_ch.entry_count = out_cnt_r;

endmodule

[hdl/keyed_fifo_queue.sv]
// Top level: keyed queue built from a microcode sequencer and a datapath.
//
//   channel  dir  handshake     word
//   in_ch    in   valid/ready   mode, key_letter, entry_value
//   out_ch   out  valid/ready   status, out_letter, out_value, entry_count
//
// One word at a time; the next word is taken the cycle after a result loads.
// Steps: append checks for a full queue, then writes the tail entry or reports full; peek and
// pop read the head entry, and pop then moves every later entry up one place; get and remove
// scan from the head until a key matches or the last entry misses, and remove then moves every
// later entry up through the memory's single port. An empty queue or an unused mode misses.
// A result waiting in the output register stalls only the final step of the next word.
// Synchronous active-low reset empties the queue; memory contents are not cleared.
`timescale 1ns / 1ps

module keyed_fifo_queue (
  input  logic       clk,
  input  logic       rst_n,
  kfq_in_if.sink     in_ch,
  kfq_out_if.source  out_ch
);

  kfq_pkg::cmd_t   cmd;
  kfq_pkg::flags_t flags;

  kfq_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cmd   (cmd)
  );

  kfq_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .flags  (flags),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

[hdl/kfq_chk.sv]
// Port checker for the keyed queue, bound to the top level.
`timescale 1ns / 1ps

module kfq_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic [1:0] status,
  input logic [7:0] out_letter,
  input logic [7:0] out_value,
  input logic [4:0] entry_count
);

  // One word in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == kfq_pkg::ST_OK || status == kfq_pkg::ST_MISS ||
                  status == kfq_pkg::ST_FULL)
    else $error("undefined status code");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != kfq_pkg::ST_OK |-> out_letter == 8'd0 && out_value == 8'd0)
    else $error("miss or full result carries entry data");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == kfq_pkg::ST_FULL |-> entry_count == 5'(kfq_pkg::DEPTH))
    else $error("full status with queue not full");

endmodule

bind keyed_fifo_queue kfq_chk u_kfq_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .status      (out_ch.status),
  .out_letter  (out_ch.out_letter),
  .out_value   (out_ch.out_value),
  .entry_count (out_ch.entry_count)
);
